// ----- design/assert_macros.svh -----
// Assertion helpers included by the stable_priority_queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
package spq_pkg;

  // Default sizes
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 32;

  // Field widths fixed by the interface
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;

  // Request kinds
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell #(
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic                      clk,
  input  spq_pkg::spq_ctrl_t        ctrl,
  input  logic                      occ,
  input  logic [TAG_BITS-1:0]       new_tag,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic                      left_keep,
  input  logic [TAG_BITS-1:0]       left_tag,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [TAG_BITS-1:0]       right_tag,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                      keep,
  output logic [TAG_BITS-1:0]       tag,
  output logic [spq_pkg::PRIO_W-1:0] prio
);

  logic [TAG_BITS-1:0]        tag_r, tag_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;

  // Hold the entry when it ranks at or above the new one
  assign keep = occ && (prio_r <= new_prio);

  // Pick the next content: hold, insert, shift toward tail or toward head
  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctrl.push && !keep) begin
      if (left_keep) begin
        tag_nxt  = new_tag;
        prio_nxt = new_prio;
      end else begin
        tag_nxt  = left_tag;
        prio_nxt = left_prio;
      end
    end else if (ctrl.pop) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag  = tag_r;
  assign prio = prio_r;

endmodule

// ----- design/stable_priority_queue.sv -----
// A result is registered and presented in the cycle after its request transaction.
// Throughput: one request per cycle while the output is not stalled; every cell updates in parallel.
// A request is taken while the output register is empty or being drained.
// Reset (synchronous, rst_n low) empties the queue and clears the output valid.
// Entry contents are not reset; only slots below the fill count are ever read.
module stable_priority_queue #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_W       = TAG_BITS + spq_pkg::PRIO_W,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = TAG_BITS + spq_pkg::PRIO_W + CNT_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_TDATA_W-1:0]        in_tdata,   // item_tag, item_priority, zero fill
  input  logic                         in_tuser,   // req_type
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,  // out_tag, out_priority, occupancy, zero fill
  output logic [spq_pkg::STATUS_W-1:0] out_tuser   // status
);

  localparam int PW = spq_pkg::PRIO_W;

  logic                in_fire;
  logic [TAG_BITS-1:0] req_tag;
  logic [PW-1:0]       req_prio;
  logic                full, empty;
  spq_pkg::spq_ctrl_t  ctrl;

  logic [CNT_W-1:0] count_r, count_nxt;

  logic [DEPTH-1:0]    occ, keep;
  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  logic [PW-1:0]       cell_prio [DEPTH];

  logic                         out_valid_r, out_valid_nxt;
  logic [spq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TAG_BITS-1:0]          out_tag_r, out_tag_nxt;
  logic [PW-1:0]                out_prio_r, out_prio_nxt;
  logic [CNT_W-1:0]             out_occ_r;

  // Take a request while the output slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign req_tag   = in_tdata[TAG_BITS-1:0];
  assign req_prio  = in_tdata[IN_W-1:TAG_BITS];

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Broadcast the command to the cells
  always_comb begin
    ctrl.push = in_fire && (in_tuser == spq_pkg::REQ_ENQ) && !full;
    ctrl.pop  = in_fire && (in_tuser == spq_pkg::REQ_DEQ) && !empty;
  end

  // Advance the fill count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Build the row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                lk;
    logic [TAG_BITS-1:0] lt, rt;
    logic [PW-1:0]       lp, rp;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lt = req_tag;
      assign lp = req_prio;
    end else begin : g_mid
      assign lk = keep[i-1];
      assign lt = cell_tag[i-1];
      assign lp = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rt = cell_tag[i];
      assign rp = cell_prio[i];
    end else begin : g_body
      assign rt = cell_tag[i+1];
      assign rp = cell_prio[i+1];
    end

    spq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .new_tag   (req_tag),
      .new_prio  (req_prio),
      .left_keep (lk),
      .left_tag  (lt),
      .left_prio (lp),
      .right_tag (rt),
      .right_prio(rp),
      .keep      (keep[i]),
      .tag       (cell_tag[i]),
      .prio      (cell_prio[i])
    );
  end

  // Form the result of the accepted request
  always_comb begin
    out_status_nxt = spq_pkg::ST_DONE;
    out_tag_nxt    = '0;
    out_prio_nxt   = '0;
    if (in_tuser == spq_pkg::REQ_ENQ) begin
      if (full) begin
        out_status_nxt = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      out_status_nxt = spq_pkg::ST_EMPTY;
    end else begin
      out_tag_nxt  = cell_tag[0];
      out_prio_nxt = cell_prio[0];
    end
  end

  // Hold the output until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= out_status_nxt;
      out_tag_r    <= out_tag_nxt;
      out_prio_r   <= out_prio_nxt;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_occ_r, out_prio_r, out_tag_r});

  `include "assert_macros.svh"

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `ASSERT_CLK(a_push_grows, clk, rst_n, ctrl.push |=> count_r == $past(count_r) + CNT_W'(1), "push did not grow the queue")
  `ASSERT_CLK(a_occ_match, clk, rst_n, in_fire |=> out_occ_r == count_r, "reported occupancy differs from fill count")
  `ASSERT_CLK(a_full_occ, clk, rst_n, (out_valid_r && out_status_r == spq_pkg::ST_FULL) |-> out_occ_r == CNT_W'(DEPTH), "full drop without full occupancy")
  `ASSERT_CLK(a_keep_sorted, clk, rst_n, ((keep >> 1) & ~keep) == '0, "cell keep flags not contiguous from head")

endmodule

// ----- tb/tb_stable_priority_queue.sv -----
`timescale 1ns / 1ps

module tb_stable_priority_queue;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEF;
  localparam int TAG_W       = spq_pkg::TAG_BITS_DEF;
  localparam int PRIO_W      = spq_pkg::PRIO_W;
  localparam int STATUS_W    = spq_pkg::STATUS_W;
  localparam int CNT_W       = $clog2(QDEPTH + 1);
  localparam int IN_W        = TAG_W + PRIO_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = TAG_W + PRIO_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int RANDOM_REQS = 1000;
  localparam int IDLE_PCT    = 24;
  localparam int HOLD_CYCLES = 70;

  typedef struct {
    logic              kind;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [PRIO_W-1:0]   prio;
    logic [CNT_W-1:0]    occupancy;
  } queue_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // item_tag, item_priority, zero fill
  logic                   in_tuser = 1'b0; // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_tag, out_priority, occupancy, zero fill
  logic [STATUS_W-1:0]    out_tuser;       // status

  // Shadow copy of the queue contents
  logic [TAG_W-1:0]  shadow_tag [QDEPTH];
  logic [PRIO_W-1:0] shadow_prio [QDEPTH];
  int                shadow_fill = 0;

  request_t     pending_reqs[$];
  queue_reply_t expected_replies[$];
  request_t     offered;
  queue_reply_t want;
  bit           offer_taken = 1'b0;
  int           total_reqs = 0;
  int           accepted_reqs = 0;
  int           err_count = 0;
  int           hold_left = 0;
  int           holds_done = 0;
  int           hold_at[2] = '{100, 600};

  // No idling on either side while this window of requests goes through
  wire calm = (accepted_reqs >= 300) && (accepted_reqs < 500);

  stable_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow queue and record the reply it must produce
  task automatic queue_model_update(input request_t req);
    queue_reply_t rep;
    int pos;
    rep = '{status: spq_pkg::ST_DONE, tag: '0, prio: '0, occupancy: '0};
    if (req.kind == spq_pkg::REQ_ENQ) begin
      if (shadow_fill >= QDEPTH) begin
        rep.status = spq_pkg::ST_FULL;
      end else begin
        // insert behind every entry of equal or higher priority
        pos = 0;
        while (pos < shadow_fill && shadow_prio[pos] <= req.prio) pos++;
        for (int i = shadow_fill; i > pos; i--) begin
          shadow_tag[i]  = shadow_tag[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_tag[pos]  = req.tag;
        shadow_prio[pos] = req.prio;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        rep.status = spq_pkg::ST_EMPTY;
      end else begin
        rep.tag  = shadow_tag[0];
        rep.prio = shadow_prio[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_tag[i-1]  = shadow_tag[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_fill--;
      end
    end
    rep.occupancy = CNT_W'(shadow_fill);
    expected_replies.push_back(rep);
  endtask

  task automatic add_req(input logic kind, input logic [TAG_W-1:0] tag,
                         input logic [PRIO_W-1:0] prio);
    request_t r;
    r.kind = kind;
    r.tag  = tag;
    r.prio = prio;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  // Sender: hold a transaction until taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || offer_taken) begin
      offer_taken = 1'b0;
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        offered = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, offered.prio, offered.tag};
        in_tuser  <= offered.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure plus two long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && accepted_reqs >= hold_at[holds_done]) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: check each result transaction, then predict for each request transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result transaction with no request outstanding");
          err_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            err_count++;
          end
          if (out_tdata[TAG_W-1:0] !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, out_tdata[TAG_W-1:0]);
            err_count++;
          end
          if (out_tdata[TAG_W +: PRIO_W] !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio,
                   out_tdata[TAG_W +: PRIO_W]);
            err_count++;
          end
          if (out_tdata[TAG_W+PRIO_W +: CNT_W] !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy,
                   out_tdata[TAG_W+PRIO_W +: CNT_W]);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        queue_model_update(offered);
        offer_taken = 1'b1;
        accepted_reqs++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    int enq_pct;
    int burst;
    logic kind;
    logic [TAG_W-1:0] tag;
    logic [PRIO_W-1:0] prio;

    // dequeue while empty, fields set to ignored extremes
    add_req(spq_pkg::REQ_DEQ, {TAG_W{1'b1}}, 2'd3);
    // tag and priority extremes, priority zero ranks above one
    add_req(spq_pkg::REQ_ENQ, '0, 2'd3);
    add_req(spq_pkg::REQ_ENQ, {TAG_W{1'b1}}, 2'd1);
    add_req(spq_pkg::REQ_ENQ, 32'hA5A5_A5A5, 2'd2);
    add_req(spq_pkg::REQ_ENQ, 32'h5A5A_5A5A, 2'd0);
    // fill to the top with ties at every priority
    for (int k = 0; k < 12; k++) begin
      add_req(spq_pkg::REQ_ENQ, 32'h1000_0000 + k, PRIO_W'(k % 4));
    end
    // enqueue into a full queue
    add_req(spq_pkg::REQ_ENQ, 32'hDEAD_BEEF, 2'd1);
    for (int k = 0; k < 5; k++) add_req(spq_pkg::REQ_DEQ, '0, '0);

    // random bursts, each with its own mix of enqueues and dequeues, from draining to filling
    n = 0;
    while (n < RANDOM_REQS) begin
      case ($urandom_range(3))
        0: enq_pct = 15;
        1: enq_pct = 50;
        2: enq_pct = 70;
        default: enq_pct = 90;
      endcase
      burst = $urandom_range(10, 60);
      for (int j = 0; j < burst && n < RANDOM_REQS; j++) begin
        kind = ($urandom_range(99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        case ($urandom_range(9))
          0: tag = '0;
          1: tag = {TAG_W{1'b1}};
          default: tag = $urandom;
        endcase
        prio = ($urandom_range(19) == 0) ? 2'd0 : PRIO_W'($urandom_range(1, 3));
        add_req(kind, tag, prio);
        n++;
      end
    end

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_reqs < total_reqs || expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
